// ===== hdl/ba_pkg.sv =====
`default_nettype none
package ba_pkg;

  localparam int UNIT_ALIGN = 4;
  localparam int MIN_BLOCK  = 8;
  localparam int POOL_RESET = 4096;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_CLEAR = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_ZERO = 2'd1,
    ST_OOM  = 2'd2
  } status_t;

  typedef struct packed {
    status_t     status;
    logic [15:0] start_index;
    logic [15:0] used_now;
    logic [15:0] free_now;
    logic [31:0] alloc_count;
    logic [15:0] peak_used;
    logic [15:0] largest_grant;
    logic [15:0] smallest_grant;
  } rsp_t;

endpackage
`default_nettype wire

// ===== hdl/ba_if.sv =====
`default_nettype none
interface ba_req_if;
  import ba_pkg::*;
  logic        valid;
  logic        ready;
  op_t         op;
  logic [15:0] request_bytes;
  logic [3:0]  align_log2;

  modport source (output valid, output op, output request_bytes, output align_log2,
                  input ready);
  modport sink (input valid, input op, input request_bytes, input align_log2,
                output ready);
endinterface

interface ba_rsp_if;
  import ba_pkg::*;
  logic        valid;
  logic        ready;
  status_t     status;
  logic [15:0] start_index;
  logic [15:0] used_now;
  logic [15:0] free_now;
  logic [31:0] alloc_count;
  logic [15:0] peak_used;
  logic [15:0] largest_grant;
  logic [15:0] smallest_grant;

  modport source (output valid, output status, output start_index, output used_now,
                  output free_now, output alloc_count, output peak_used,
                  output largest_grant, output smallest_grant, input ready);
  modport sink (input valid, input status, input start_index, input used_now,
                input free_now, input alloc_count, input peak_used,
                input largest_grant, input smallest_grant, output ready);
endinterface
`default_nettype wire

// ===== hdl/bump_arena_allocator.sv =====
// result word: registered from the accepted request word, or held in the skid register first while out is stalled
// throughput: one request per cycle while the skid register is empty; ready drops while it holds a result
// a skid register holds one extra result so a request is taken while out is stalled
// reset (rst, synchronous): pool size 4096, fill offset and statistics cleared,
// no result pending
`default_nettype none
module bump_arena_allocator (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_wr_en,
  input  wire logic [15:0] cfg_wr_data,
  ba_req_if.sink           req,
  ba_rsp_if.source         rsp
);
  import ba_pkg::*;

  logic [15:0] pool_bytes;
  logic [15:0] fill_offset;
  logic [31:0] grant_count;
  logic [15:0] peak_fill;
  logic [15:0] max_grant;
  logic [15:0] min_grant;

  logic [15:0] fill_offset_next;
  logic [31:0] grant_count_next;
  logic [15:0] peak_fill_next;
  logic [15:0] max_grant_next;
  logic [15:0] min_grant_next;

  rsp_t out_word;
  rsp_t skid_word;
  rsp_t word_next;
  logic out_valid;
  logic skid_valid;

  logic        accept;
  logic [16:0] rounded;
  logic [16:0] size;
  logic [16:0] align_mask;
  logic [16:0] aligned;
  logic [17:0] end_sum;
  logic        fits;
  status_t     status_next;
  logic [15:0] start_next;

  assign accept    = req.valid && req.ready;
  assign req.ready = !skid_valid;

  // size rounding and alignment padding
  always_comb begin
    rounded    = 17'(({1'b0, req.request_bytes} + 17'(UNIT_ALIGN - 1))
                     / 17'(UNIT_ALIGN) * 17'(UNIT_ALIGN));
    size       = (rounded < 17'(MIN_BLOCK)) ? 17'(MIN_BLOCK) : rounded;
    align_mask = (17'd1 << req.align_log2) - 17'd1;
    aligned    = ({1'b0, fill_offset} + align_mask) & ~align_mask;
    end_sum    = {1'b0, aligned} + {1'b0, size};
    fits       = !size[16] && (end_sum <= {2'b00, pool_bytes});
  end

  always_comb begin
    fill_offset_next = fill_offset;
    grant_count_next = grant_count;
    peak_fill_next   = peak_fill;
    max_grant_next   = max_grant;
    min_grant_next   = min_grant;
    status_next      = ST_OK;
    start_next       = '0;
    if (req.op == OP_CLEAR) begin
      fill_offset_next = '0;
      grant_count_next = '0;
      peak_fill_next   = '0;
      max_grant_next   = '0;
      min_grant_next   = '0;
    end else if (req.request_bytes == '0) begin
      status_next = ST_ZERO;
    end else if (!fits) begin
      status_next = ST_OOM;
    end else begin
      start_next       = aligned[15:0];
      fill_offset_next = end_sum[15:0];
      if (grant_count == '0 || size[15:0] < min_grant) begin
        min_grant_next = size[15:0];
      end
      if (grant_count != '1) begin
        grant_count_next = grant_count + 32'd1;
      end
      if (end_sum[15:0] > peak_fill) begin
        peak_fill_next = end_sum[15:0];
      end
      if (size[15:0] > max_grant) begin
        max_grant_next = size[15:0];
      end
    end
    word_next.status         = status_next;
    word_next.start_index    = start_next;
    word_next.used_now       = fill_offset_next;
    word_next.free_now       = (pool_bytes > fill_offset_next) ?
                               (pool_bytes - fill_offset_next) : '0;
    word_next.alloc_count    = grant_count_next;
    word_next.peak_used      = peak_fill_next;
    word_next.largest_grant  = max_grant_next;
    word_next.smallest_grant = min_grant_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pool_bytes  <= 16'(POOL_RESET);
      fill_offset <= '0;
      grant_count <= '0;
      peak_fill   <= '0;
      max_grant   <= '0;
      min_grant   <= '0;
    end else begin
      if (cfg_wr_en) begin
        pool_bytes <= cfg_wr_data;
      end
      if (accept) begin
        fill_offset <= fill_offset_next;
        grant_count <= grant_count_next;
        peak_fill   <= peak_fill_next;
        max_grant   <= max_grant_next;
        min_grant   <= min_grant_next;
      end
    end
  end

  // output register plus skid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (out_valid && !rsp.ready) begin
        if (accept) begin
          skid_valid <= 1'b1;
        end
      end else if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= accept;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_valid && !rsp.ready) begin
      if (accept) begin
        skid_word <= word_next;
      end
    end else if (skid_valid) begin
      out_word <= skid_word;
    end else if (accept) begin
      out_word <= word_next;
    end
  end

  assign rsp.valid          = out_valid;
  assign rsp.status         = out_word.status;
  assign rsp.start_index    = out_word.start_index;
  assign rsp.used_now       = out_word.used_now;
  assign rsp.free_now       = out_word.free_now;
  assign rsp.alloc_count    = out_word.alloc_count;
  assign rsp.peak_used      = out_word.peak_used;
  assign rsp.largest_grant  = out_word.largest_grant;
  assign rsp.smallest_grant = out_word.smallest_grant;

  a_skid_needs_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid word held without output word");

  a_peak_covers_fill: assert property (@(posedge clk) disable iff (rst)
    peak_fill >= fill_offset)
    else $error("peak fill below fill offset");

  a_count_monotonic: assert property (@(posedge clk) disable iff (rst)
    (accept && req.op == OP_ALLOC) |=> grant_count >= $past(grant_count))
    else $error("grant count dropped on allocate");

  a_fill_moves_on_ok: assert property (@(posedge clk) disable iff (rst)
    (accept && req.op == OP_ALLOC && status_next != ST_OK) |=>
      fill_offset == $past(fill_offset))
    else $error("failed request changed fill offset");

endmodule
`default_nettype wire

// ===== sim/tb.sv =====
`default_nettype none
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ba_pkg::*;

  localparam int LIMIT       = 200000;
  localparam int PHASE_WORDS = 100;

  typedef enum logic {ROW_WORD, ROW_POOL} row_kind_t;

  typedef struct {
    row_kind_t   kind;
    op_t         op;
    logic [15:0] bytes;
    logic [3:0]  alog;
    bit          pinned;
    rsp_t        want;
  } row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_wr_en;
  logic [15:0] cfg_wr_data;

  ba_req_if req();
  ba_rsp_if rsp();

  bump_arena_allocator dut (
    .clk(clk),
    .rst(rst),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .req(req),
    .rsp(rsp)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // arena state as the block should hold it
  logic [31:0] arena_len;
  logic [31:0] fill;
  logic [31:0] grants;
  logic [31:0] peak;
  logic [31:0] max_sz;
  logic [31:0] min_sz;

  rsp_t        pending[$];
  rsp_t        head_word;
  bit          pin_on;
  rsp_t        pin_word;
  bit          idle_on;
  bit          stall_on;
  int          errors = 0;
  int          cycles = 0;
  int          n_words, n_grant, n_oom, n_zero, n_clear, n_pool;

  function automatic rsp_t snap(status_t s, int st, int us, int fr, int cnt, int pk, int lg,
                                int sm);
    rsp_t r;
    r.status         = s;
    r.start_index    = 16'(st);
    r.used_now       = 16'(us);
    r.free_now       = 16'(fr);
    r.alloc_count    = 32'(cnt);
    r.peak_used      = 16'(pk);
    r.largest_grant  = 16'(lg);
    r.smallest_grant = 16'(sm);
    return r;
  endfunction

  function automatic rsp_t arena_step(op_t o, logic [15:0] b, logic [3:0] a);
    logic [31:0] sz;
    logic [31:0] span;
    logic [31:0] base;
    logic [31:0] stop;
    rsp_t        r;
    r.status      = ST_OK;
    r.start_index = '0;
    if (o == OP_CLEAR) begin
      fill   = '0;
      grants = '0;
      peak   = '0;
      max_sz = '0;
      min_sz = '0;
      n_clear++;
    end else if (b == 16'd0) begin
      r.status = ST_ZERO;
      n_zero++;
    end else begin
      sz = ((32'(b) + UNIT_ALIGN - 1) / UNIT_ALIGN) * UNIT_ALIGN;
      if (sz < MIN_BLOCK) sz = MIN_BLOCK;
      span = 32'd1 << a;
      base = (fill + span - 1) & ~(span - 1);
      stop = base + sz;
      if (sz > 32'hffff || stop > arena_len) begin
        r.status = ST_OOM;
        n_oom++;
      end else begin
        r.start_index = base[15:0];
        fill = stop;
        if (grants == 0 || sz < min_sz) min_sz = sz;
        if (grants != 32'hffff_ffff) grants++;
        if (fill > peak) peak = fill;
        if (sz > max_sz) max_sz = sz;
        n_grant++;
      end
    end
    r.used_now       = fill[15:0];
    r.free_now       = (arena_len > fill) ? 16'(arena_len - fill) : 16'd0;
    r.alloc_count    = grants;
    r.peak_used      = peak[15:0];
    r.largest_grant  = max_sz[15:0];
    r.smallest_grant = min_sz[15:0];
    return r;
  endfunction

  task automatic check_field(string tag, logic [31:0] want, logic [31:0] seen);
    if (seen !== want) begin
      $display("%0t mismatch %s: expected %0d actual %0d", $time, tag, want, seen);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      arena_len = 32'(POOL_RESET);
      fill      = '0;
      grants    = '0;
      peak      = '0;
      max_sz    = '0;
      min_sz    = '0;
    end else begin
      if (cfg_wr_en) arena_len = 32'(cfg_wr_data);
      if (req.valid && req.ready) begin
        head_word = arena_step(req.op, req.request_bytes, req.align_log2);
        if (pin_on) head_word = pin_word;
        pending.push_back(head_word);
        n_words++;
      end
      if (rsp.valid && rsp.ready) begin
        if (pending.size() == 0) begin
          $display("%0t unexpected result word: expected none actual status %0d", $time,
                   rsp.status);
          errors++;
        end else begin
          head_word = pending.pop_front();
          check_field("status", 32'(head_word.status), 32'(rsp.status));
          check_field("start_index", 32'(head_word.start_index), 32'(rsp.start_index));
          check_field("used_now", 32'(head_word.used_now), 32'(rsp.used_now));
          check_field("free_now", 32'(head_word.free_now), 32'(rsp.free_now));
          check_field("alloc_count", head_word.alloc_count, rsp.alloc_count);
          check_field("peak_used", 32'(head_word.peak_used), 32'(rsp.peak_used));
          check_field("largest_grant", 32'(head_word.largest_grant),
                      32'(rsp.largest_grant));
          check_field("smallest_grant", 32'(head_word.smallest_grant),
                      32'(rsp.smallest_grant));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("%0t timeout with %0d results outstanding", $time, pending.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // result side backpressure
  initial begin
    rsp.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (stall_on && $urandom_range(0, 4) == 0) begin
        rsp.ready <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk);
      end
      rsp.ready <= 1'b1;
    end
  end

  task automatic put_word(op_t o, logic [15:0] b, logic [3:0] a, bit pin, rsp_t pw);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      req.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    req.valid         <= 1'b1;
    req.op            <= o;
    req.request_bytes <= b;
    req.align_log2    <= a;
    pin_on            <= pin;
    pin_word          <= pw;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
  endtask

  task automatic wait_all_returned();
    req.valid <= 1'b0;
    @(posedge clk);
    while (pending.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic set_pool(logic [15:0] v);
    wait_all_returned();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    n_pool++;
  endtask

  initial begin
    row_t        plan[$];
    logic [15:0] phase_pool[5];
    int          roll;
    op_t         o;
    logic [15:0] b;
    logic [3:0]  a;

    req.valid         = 1'b0;
    req.op            = OP_ALLOC;
    req.request_bytes = '0;
    req.align_log2    = '0;
    cfg_wr_en         = 1'b0;
    cfg_wr_data       = '0;
    pin_on            = 1'b0;
    pin_word          = '0;
    idle_on           = 1'b1;
    stall_on          = 1'b1;

    // zero size, minimum block, oversize rounding, huge alignment, exact fit, clear
    plan.push_back('{ROW_WORD, OP_ALLOC, 16'd0, 4'd0, 1'b1,
                     snap(ST_ZERO, 0, 0, 4096, 0, 0, 0, 0)});
    plan.push_back('{ROW_WORD, OP_ALLOC, 16'd1, 4'd0, 1'b1,
                     snap(ST_OK, 0, 8, 4088, 1, 8, 8, 8)});
    plan.push_back('{ROW_WORD, OP_ALLOC, 16'hffff, 4'd0, 1'b1,
                     snap(ST_OOM, 0, 8, 4088, 1, 8, 8, 8)});
    plan.push_back('{ROW_WORD, OP_ALLOC, 16'hfffd, 4'd0, 1'b1,
                     snap(ST_OOM, 0, 8, 4088, 1, 8, 8, 8)});
    plan.push_back('{ROW_WORD, OP_ALLOC, 16'd5, 4'd15, 1'b1,
                     snap(ST_OOM, 0, 8, 4088, 1, 8, 8, 8)});
    plan.push_back('{ROW_WORD, OP_ALLOC, 16'd13, 4'd4, 1'b0, '0});
    plan.push_back('{ROW_WORD, OP_ALLOC, 16'd4064, 4'd0, 1'b0, '0});
    plan.push_back('{ROW_WORD, OP_ALLOC, 16'd1, 4'd0, 1'b0, '0});
    plan.push_back('{ROW_WORD, OP_CLEAR, 16'hffff, 4'd15, 1'b1,
                     snap(ST_OK, 0, 0, 4096, 0, 0, 0, 0)});
    plan.push_back('{ROW_POOL, OP_ALLOC, 16'hffff, 4'd0, 1'b0, '0});
    plan.push_back('{ROW_WORD, OP_ALLOC, 16'd65532, 4'd0, 1'b0, '0});
    plan.push_back('{ROW_WORD, OP_ALLOC, 16'd3, 4'd2, 1'b0, '0});
    plan.push_back('{ROW_WORD, OP_CLEAR, 16'd0, 4'd0, 1'b1,
                     snap(ST_OK, 0, 0, 65535, 0, 0, 0, 0)});
    plan.push_back('{ROW_WORD, OP_ALLOC, 16'd7, 4'd15, 1'b0, '0});
    plan.push_back('{ROW_WORD, OP_ALLOC, 16'd9, 4'd15, 1'b0, '0});
    plan.push_back('{ROW_WORD, OP_ALLOC, 16'd100, 4'd3, 1'b0, '0});
    // pool shrunk below the fill offset
    plan.push_back('{ROW_POOL, OP_ALLOC, 16'd16, 4'd0, 1'b0, '0});
    plan.push_back('{ROW_WORD, OP_ALLOC, 16'd1, 4'd0, 1'b0, '0});
    plan.push_back('{ROW_WORD, OP_ALLOC, 16'd0, 4'd0, 1'b0, '0});
    plan.push_back('{ROW_WORD, OP_CLEAR, 16'd0, 4'd0, 1'b1,
                     snap(ST_OK, 0, 0, 16, 0, 0, 0, 0)});
    plan.push_back('{ROW_POOL, OP_ALLOC, 16'd1, 4'd0, 1'b0, '0});
    plan.push_back('{ROW_WORD, OP_ALLOC, 16'd1, 4'd0, 1'b1,
                     snap(ST_OOM, 0, 0, 1, 0, 0, 0, 0)});

    phase_pool[0] = 16'd4096;
    phase_pool[1] = 16'hffff;
    phase_pool[2] = 16'd256;
    phase_pool[3] = 16'($urandom_range(1, 65535));
    phase_pool[4] = 16'd4096;

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_POOL) begin
        set_pool(plan[i].bytes);
      end else begin
        put_word(plan[i].op, plan[i].bytes, plan[i].alog, plan[i].pinned, plan[i].want);
      end
    end

    for (int p = 0; p < 5; p++) begin
      set_pool(phase_pool[p]);
      if (p == 4) begin
        idle_on  = 1'b0;
        stall_on = 1'b0;
      end
      for (int k = 0; k < PHASE_WORDS; k++) begin
        if (p == 0 && k == PHASE_WORDS / 2) wait_all_returned();
        roll = $urandom_range(0, 99);
        o = (roll < 7) ? OP_CLEAR : OP_ALLOC;
        if (roll < 7 || roll >= 95) b = 16'($urandom_range(0, 65535));
        else if (roll < 11) b = 16'd0;
        else if (roll < 70) b = 16'($urandom_range(1, 64));
        else b = 16'($urandom_range(1, 1024));
        a = ($urandom_range(0, 9) < 7) ? 4'($urandom_range(0, 4)) : 4'($urandom_range(0, 15));
        put_word(o, b, a, 1'b0, '0);
      end
    end

    wait_all_returned();
    repeat (8) @(posedge clk);
    $display("covered %0d request words over %0d pool sizes: %0d grants, %0d out of memory,",
             n_words, n_pool, n_grant, n_oom);
    $display("%0d zero size, %0d clears, %0d mismatches", n_zero, n_clear, errors);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ===== files.f =====
hdl/ba_pkg.sv
hdl/ba_if.sv
hdl/bump_arena_allocator.sv
sim/tb.sv
